### design/famu_pkg.sv
// Shared types, constants and saturation helpers for the fin actuator model.
// Used by the controller, the datapath, the multiply unit, the top level and the checker.
package famu_pkg;

	// stream payload and configuration port
	localparam int DATA_W     = 32;
	localparam int TDATA_W    = 3 * DATA_W;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	// configuration register indexes
	localparam logic [CFG_ADDR_W-1:0] CFG_IDX_POS_LIMIT  = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_IDX_RATE_LIMIT = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_IDX_NAT_FREQ   = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] CFG_IDX_DAMPING    = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] CFG_IDX_TIME_STEP  = 3'd4;

	// configuration reset values
	localparam logic [30:0] POS_LIMIT_RST  = 31'd8199025;
	localparam logic [30:0] RATE_LIMIT_RST = 31'd175691006;
	localparam logic [23:0] NAT_FREQ_RST   = 24'd409600;
	localparam logic [15:0] DAMPING_RST    = 16'd11469;
	localparam logic [31:0] TIME_STEP_RST  = 32'd4294967;

	// fin indexing
	localparam int               FIN_IDX_W = 2;
	localparam int               FINS      = 4;
	localparam logic [FIN_IDX_W-1:0] FIN_LAST = 2'd3;

	// shared multiplier: signed operand, split into two halves
	localparam int MUL_A_W    = 50;
	localparam int MUL_HALF_W = 25;
	localparam int MUL_B_W    = 32;
	localparam int MUL_RES_W  = 64;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLAMP,
		ST_MUL,
		ST_WAIT,
		ST_MIX,
		ST_OUT
	} state_t;

	// multiply unit phases
	typedef enum logic [2:0] {
		MPH_IDLE,
		MPH_ABS,
		MPH_LO,
		MPH_HI,
		MPH_SUM,
		MPH_OUT
	} mul_phase_t;

	// multiply steps of one fin update, in order
	typedef enum logic [2:0] {
		STEP_POS,   // (rate + previous slope) * dt
		STEP_ERR,   // error * wn
		STEP_WN,    // (error * wn) * wn
		STEP_DAMP,  // rate * 2 zeta wn
		STEP_RATE   // (acc + previous acc) * dt
	} step_t;

	typedef struct packed {
		logic                 load;
		logic                 clamp;
		logic                 mul_start;
		logic                 mul_take;
		step_t                step;
		logic [FIN_IDX_W-1:0] fin;
		logic                 mix;
		logic                 out_load;
	} famu_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic mul_busy;
	} famu_sts_t;

	// saturate a wide signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v[65:31] != {35{v[65]}})
			return v[65] ? {1'b1, {31{1'b0}}} : {1'b0, {31{1'b1}}};
		return v[31:0];
	endfunction

	// saturate a wide signed value to 40 bits
	function automatic logic signed [39:0] sat40(input logic signed [65:0] v);
		if (v[65:39] != {27{v[65]}})
			return v[65] ? {1'b1, {39{1'b0}}} : {1'b0, {39{1'b1}}};
		return v[39:0];
	endfunction

	// saturate a wide signed value to 41 bits
	function automatic logic signed [40:0] sat41(input logic signed [65:0] v);
		if (v[65:40] != {26{v[65]}})
			return v[65] ? {1'b1, {40{1'b0}}} : {1'b0, {40{1'b1}}};
		return v[40:0];
	endfunction

	// saturate a wide signed value to 48 bits
	function automatic logic signed [47:0] sat48(input logic signed [65:0] v);
		if (v[65:47] != {19{v[65]}})
			return v[65] ? {1'b1, {47{1'b0}}} : {1'b0, {47{1'b1}}};
		return v[47:0];
	endfunction

endpackage

### design/famu_mul.sv
// Shared signed-by-unsigned multiply, shift right by 12 or 33 with truncation toward zero.
// One 25x32 multiplier used twice per operation; depends on famu_pkg.
module famu_mul import famu_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic signed [MUL_A_W-1:0]   a,
	input  logic        [MUL_B_W-1:0]   b,
	input  logic                        sh_long,
	output logic                        done,
	output logic                        busy,
	output logic signed [MUL_RES_W-1:0] res
);

	mul_phase_t                      phase_q;
	mul_phase_t                      phase_nxt;
	logic                            done_q;
	logic signed [MUL_A_W-1:0]       a_q;
	logic        [MUL_B_W-1:0]       b_q;
	logic                            sh_long_q;
	logic                            neg_q;
	logic        [MUL_A_W-1:0]       mag_q;
	logic        [MUL_HALF_W+MUL_B_W-1:0] lo_q;
	logic        [MUL_HALF_W+MUL_B_W-1:0] hi_q;
	logic        [MUL_HALF_W+MUL_B_W-1:0] prod;
	logic        [MUL_HALF_W-1:0]    mul_in;
	logic        [81:0]              sum_q;
	logic        [69:0]              shifted;
	logic        [61:0]              capped;
	logic signed [MUL_RES_W-1:0]     mag_ext;
	logic signed [MUL_RES_W-1:0]     res_q;

	// pick the low or high half of the magnitude for the single multiplier
	assign mul_in = (phase_q == MPH_LO) ? mag_q[MUL_HALF_W-1:0] : mag_q[MUL_A_W-1:MUL_HALF_W];
	assign prod   = mul_in * b_q;

	// align, then cap the magnitude at 2^62 - 1
	assign shifted = sh_long_q ? {21'b0, sum_q[81:33]} : sum_q[81:12];
	assign capped  = (|shifted[69:62]) ? '1 : shifted[61:0];
	assign mag_ext = signed'({2'b00, capped});

	// next phase
	always_comb begin
		phase_nxt = phase_q;
		unique case (phase_q)
			MPH_IDLE: if (start) phase_nxt = MPH_ABS;
			MPH_ABS:  phase_nxt = MPH_LO;
			MPH_LO:   phase_nxt = MPH_HI;
			MPH_HI:   phase_nxt = MPH_SUM;
			MPH_SUM:  phase_nxt = MPH_OUT;
			MPH_OUT:  phase_nxt = MPH_IDLE;
			default:  phase_nxt = MPH_IDLE;
		endcase
	end

	// sequence the phases
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= MPH_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q  <= (phase_q == MPH_OUT);
			phase_q <= phase_nxt;
		end
	end

	// operand capture and partial products
	always_ff @(posedge clk) begin
		if (start && phase_q == MPH_IDLE) begin
			a_q       <= a;
			b_q       <= b;
			sh_long_q <= sh_long;
		end
		if (phase_q == MPH_ABS) begin
			neg_q <= a_q[MUL_A_W-1];
			mag_q <= a_q[MUL_A_W-1] ? MUL_A_W'(-a_q) : MUL_A_W'(a_q);
		end
		if (phase_q == MPH_LO)
			lo_q <= prod;
		if (phase_q == MPH_HI)
			hi_q <= prod;
		if (phase_q == MPH_SUM)
			sum_q <= {hi_q, {MUL_HALF_W{1'b0}}} + 82'(lo_q);
		if (phase_q == MPH_OUT)
			res_q <= neg_q ? -mag_ext : mag_ext;
	end

	assign done = done_q;
	assign busy = (phase_q != MPH_IDLE);
	assign res  = res_q;

endmodule

### design/famu_dp.sv
// Datapath of the fin actuator model: configuration, fin state, clamps, mixing and output.
// Uses famu_mul for every step product; driven by famu_ctrl; depends on famu_pkg.
module famu_dp import famu_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [TDATA_W-1:0]    in_data,
	input  famu_cmd_t             cmd,
	output famu_sts_t             sts,
	output logic [TDATA_W-1:0]    out_data
);

	// configuration
	logic [30:0] plim_q;
	logic [30:0] rlim_q;
	logic [23:0] wn_q;
	logic [15:0] zeta_q;
	logic [31:0] dt_q;

	// fin state
	logic signed [39:0] pos_q   [FINS];
	logic signed [39:0] slope_q [FINS];
	logic signed [39:0] rate_q  [FINS];
	logic signed [47:0] accp_q  [FINS];

	// per-item and per-fin working registers
	logic signed [31:0] roll_cmd_q;
	logic signed [31:0] pitch_cmd_q;
	logic signed [31:0] yaw_cmd_q;
	logic        [26:0] c_q;
	logic signed [39:0] pos_c_q;
	logic signed [39:0] rate_c_q;
	logic               flag_q;
	logic signed [33:0] cmd_q;
	logic signed [47:0] t_q;
	logic signed [47:0] acc_q;
	logic signed [41:0] roll_sum_q;
	logic signed [41:0] pitch_sum_q;
	logic signed [41:0] yaw_sum_q;
	logic signed [31:0] roll_q;
	logic signed [31:0] pitch_q;
	logic signed [31:0] yaw_q;

	// combinational
	logic        [39:0] dw_prod;
	logic signed [39:0] pos_cur;
	logic signed [39:0] rate_cur;
	logic signed [40:0] pos41;
	logic signed [40:0] rate41;
	logic signed [40:0] plim41;
	logic signed [40:0] rlim41;
	logic               pos_over;
	logic               rate_zero;
	logic               rate_over;
	logic signed [39:0] pos_clamp;
	logic signed [39:0] rate_clamp;
	logic signed [33:0] r34;
	logic signed [33:0] p34;
	logic signed [33:0] y34;
	logic signed [33:0] fin_cmd;
	logic signed [MUL_A_W-1:0]   mul_a;
	logic        [MUL_B_W-1:0]   mul_b;
	logic                        mul_long;
	logic                        mul_done;
	logic                        mul_busy;
	logic signed [MUL_RES_W-1:0] mul_res;
	logic signed [39:0] pos_new;
	logic signed [39:0] rate_new;
	logic signed [47:0] t_new;
	logic signed [47:0] acc_new;
	logic               acc_drop;
	logic signed [41:0] roll_rnd;
	logic signed [41:0] pitch_rnd;
	logic signed [41:0] yaw_rnd;

	// write configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plim_q <= POS_LIMIT_RST;
			rlim_q <= RATE_LIMIT_RST;
			wn_q   <= NAT_FREQ_RST;
			zeta_q <= DAMPING_RST;
			dt_q   <= TIME_STEP_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_IDX_POS_LIMIT:  plim_q <= cfg_data[30:0];
				CFG_IDX_RATE_LIMIT: rlim_q <= cfg_data[30:0];
				CFG_IDX_NAT_FREQ:   wn_q   <= cfg_data[23:0];
				CFG_IDX_DAMPING:    zeta_q <= cfg_data[15:0];
				CFG_IDX_TIME_STEP:  dt_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// 2 zeta wn in Q.12
	assign dw_prod = zeta_q * wn_q;

	// position and rate limits of the current fin
	assign pos_cur  = pos_q[cmd.fin];
	assign rate_cur = rate_q[cmd.fin];
	assign pos41    = 41'(pos_cur);
	assign rate41   = 41'(rate_cur);
	assign plim41   = signed'({10'b0, plim_q});
	assign rlim41   = signed'({10'b0, rlim_q});
	assign pos_over = (pos41 > plim41) || (pos41 < -plim41);
	// outward rate at the position limit is zeroed
	assign rate_zero = pos_over && (plim_q != '0) && (rate_cur != '0) &&
		(pos_cur[39] == rate_cur[39]);
	assign rate_over = !rate_zero && ((rate41 > rlim41) || (rate41 < -rlim41));
	assign pos_clamp = !pos_over ? pos_cur :
		(pos_cur[39] ? 40'(-plim41) : 40'(plim41));
	assign rate_clamp = rate_zero ? '0 :
		(!rate_over ? rate_cur : (rate_cur[39] ? 40'(-rlim41) : 40'(rlim41)));

	// fin command from roll, pitch and yaw
	assign r34     = 34'(roll_cmd_q);
	assign p34     = 34'(pitch_cmd_q);
	assign y34     = 34'(yaw_cmd_q);
	assign fin_cmd = (cmd.fin[1] ? r34 : -r34) + p34 + (cmd.fin[0] ? y34 : -y34);

	// select multiplier operands for the current step
	always_comb begin
		mul_a    = '0;
		mul_b    = dt_q;
		mul_long = 1'b1;
		unique case (cmd.step)
			STEP_POS: begin
				mul_a    = MUL_A_W'(41'(rate_c_q) + 41'(slope_q[cmd.fin]));
				mul_b    = dt_q;
				mul_long = 1'b1;
			end
			STEP_ERR: begin
				mul_a    = MUL_A_W'(sat41(66'(cmd_q) - 66'(pos_q[cmd.fin])));
				mul_b    = MUL_B_W'(wn_q);
				mul_long = 1'b0;
			end
			STEP_WN: begin
				mul_a    = MUL_A_W'(t_q);
				mul_b    = MUL_B_W'(wn_q);
				mul_long = 1'b0;
			end
			STEP_DAMP: begin
				mul_a    = MUL_A_W'(rate_c_q);
				mul_b    = MUL_B_W'(c_q);
				mul_long = 1'b0;
			end
			STEP_RATE: begin
				mul_a    = MUL_A_W'(49'(acc_q) + 49'(accp_q[cmd.fin]));
				mul_b    = dt_q;
				mul_long = 1'b1;
			end
			default: ;
		endcase
	end

	famu_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.sh_long (mul_long),
		.done    (mul_done),
		.busy    (mul_busy),
		.res     (mul_res)
	);

	assign sts.mul_done = mul_done;
	assign sts.mul_busy = mul_busy;

	// results of each step
	assign pos_new  = sat40(66'(pos_c_q) + 66'(mul_res));
	assign rate_new = sat40(66'(rate_c_q) + 66'(mul_res));
	assign t_new    = sat48(66'(mul_res));
	assign acc_new  = sat48(66'(t_q) - 66'(mul_res));
	// drop the stored acceleration when it still pushes against the rate limit
	assign acc_drop = flag_q && (rate_new != '0) && (acc_q != '0) &&
		(rate_new[39] == acc_q[47]);

	// fin state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FINS; i++) begin
				pos_q[i]   <= '0;
				slope_q[i] <= '0;
				rate_q[i]  <= '0;
				accp_q[i]  <= '0;
			end
		end else if (cmd.mul_take) begin
			case (cmd.step)
				STEP_POS: begin
					pos_q[cmd.fin]   <= pos_new;
					slope_q[cmd.fin] <= rate_c_q;
				end
				STEP_RATE: begin
					rate_q[cmd.fin] <= rate_new;
					accp_q[cmd.fin] <= acc_drop ? '0 : acc_q;
				end
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			roll_cmd_q  <= in_data[DATA_W-1:0];
			pitch_cmd_q <= in_data[2*DATA_W-1:DATA_W];
			yaw_cmd_q   <= in_data[3*DATA_W-1:2*DATA_W];
			c_q         <= dw_prod[39:13];
		end
		if (cmd.clamp) begin
			pos_c_q  <= pos_clamp;
			rate_c_q <= rate_clamp;
			flag_q   <= rate_over;
			cmd_q    <= fin_cmd;
		end
		if (cmd.mul_take) begin
			case (cmd.step)
				STEP_ERR, STEP_WN: t_q   <= t_new;
				STEP_DAMP:         acc_q <= acc_new;
				default: ;
			endcase
		end
		if (cmd.mix) begin
			roll_sum_q  <= -42'(pos_q[0]) - 42'(pos_q[1]) + 42'(pos_q[2]) + 42'(pos_q[3]);
			pitch_sum_q <= 42'(pos_q[0]) + 42'(pos_q[1]) + 42'(pos_q[2]) + 42'(pos_q[3]);
			yaw_sum_q   <= -42'(pos_q[0]) + 42'(pos_q[1]) - 42'(pos_q[2]) + 42'(pos_q[3]);
		end
		if (cmd.out_load) begin
			roll_q  <= sat32(66'(roll_rnd >>> 2));
			pitch_q <= sat32(66'(pitch_rnd >>> 2));
			yaw_q   <= sat32(66'(yaw_rnd >>> 2));
		end
	end

	// divide by four toward zero: bias negative sums before the shift
	assign roll_rnd  = roll_sum_q + (roll_sum_q[41] ? 42'sd3 : 42'sd0);
	assign pitch_rnd = pitch_sum_q + (pitch_sum_q[41] ? 42'sd3 : 42'sd0);
	assign yaw_rnd   = yaw_sum_q + (yaw_sum_q[41] ? 42'sd3 : 42'sd0);

	assign out_data = {yaw_q, pitch_q, roll_q};

endmodule

### design/famu_ctrl.sv
// Controller of the fin actuator model: walks four fins through clamp and five multiply steps.
// Drives famu_dp by command struct and owns the stream handshakes; depends on famu_pkg.
module famu_ctrl import famu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_axis_tvalid,
	output logic      s_axis_tready,
	output logic      m_axis_tvalid,
	input  logic      m_axis_tready,
	input  famu_sts_t sts,
	output famu_cmd_t cmd
);

	state_t               state_q;
	state_t               state_nxt;
	step_t                step_q;
	step_t                step_nxt;
	logic [FIN_IDX_W-1:0] fin_q;
	logic                 out_valid_q;
	logic                 out_fire;
	logic                 fin_done;

	assign out_fire = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);
	assign fin_done = (state_q == ST_WAIT) && sts.mul_done && (step_q == STEP_RATE);

	// step order
	always_comb begin
		unique case (step_q)
			STEP_POS:  step_nxt = STEP_ERR;
			STEP_ERR:  step_nxt = STEP_WN;
			STEP_WN:   step_nxt = STEP_DAMP;
			STEP_DAMP: step_nxt = STEP_RATE;
			STEP_RATE: step_nxt = STEP_POS;
			default:   step_nxt = STEP_POS;
		endcase
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:  if (s_axis_tvalid) state_nxt = ST_CLAMP;
			ST_CLAMP: state_nxt = ST_MUL;
			ST_MUL:   state_nxt = ST_WAIT;
			ST_WAIT: begin
				if (sts.mul_done) begin
					if (step_q != STEP_RATE)
						state_nxt = ST_MUL;
					else if (fin_q == FIN_LAST)
						state_nxt = ST_MIX;
					else
						state_nxt = ST_CLAMP;
				end
			end
			ST_MIX:   state_nxt = ST_OUT;
			ST_OUT:   if (out_fire) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd      = '0;
		cmd.step = step_q;
		cmd.fin  = fin_q;
		unique case (state_q)
			ST_IDLE:  cmd.load      = s_axis_tvalid;
			ST_CLAMP: cmd.clamp     = 1'b1;
			ST_MUL:   cmd.mul_start = !sts.mul_busy;
			ST_WAIT:  cmd.mul_take  = sts.mul_done;
			ST_MIX:   cmd.mix       = 1'b1;
			ST_OUT:   cmd.out_load  = out_fire;
			default: ;
		endcase
	end

	// state, fin and step counters, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= STEP_POS;
			fin_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_IDLE && s_axis_tvalid) begin
				fin_q  <= '0;
				step_q <= STEP_POS;
			end else if (state_q == ST_WAIT && sts.mul_done) begin
				step_q <= step_nxt;
			end
			if (fin_done)
				fin_q <= fin_q + 1'b1;
			if (out_fire)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;

endmodule

### design/fin_actuator_second_order_model_unit.sv
// Four-fin second-order actuator model with position and rate limits, roll/pitch/yaw mixing.
// One item in flight: a new input is taken only after the previous result is loaded for output.
// The shared 25x32 multiplier sets the rate: 5 products per fin, one at a time, 4 fins.
// A waiting result is held in the output register while the next item is taken.
// Reset (arst_n low, asynchronous) zeroes all fin state and loads the register defaults.
// Built from famu_ctrl and famu_dp; depends on famu_pkg.
module fin_actuator_second_order_model_unit import famu_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// roll_command [31:0], pitch_command [63:32], yaw_command [95:64]
	input  logic [TDATA_W-1:0]    s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// roll_deflection [31:0], pitch_deflection [63:32], yaw_deflection [95:64]
	output logic [TDATA_W-1:0]    m_axis_tdata
);

	famu_cmd_t cmd;
	famu_sts_t sts;

	famu_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.sts           (sts),
		.cmd           (cmd)
	);

	famu_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.in_data  (s_axis_tdata),
		.cmd      (cmd),
		.sts      (sts),
		.out_data (m_axis_tdata)
	);

endmodule

### design/famu_checker.sv
// Port-level checks for the fin actuator model, bound to the top level.
// Depends on famu_pkg and fin_actuator_second_order_model_unit.
module famu_checker import famu_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [TDATA_W-1:0]    m_axis_tdata
);

	// hold a stalled result
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// one item in flight: input closes right after a transaction
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input open while an item is in flight");

	// a new result appears together with the return to idle
	a_result_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> s_axis_tready)
		else $error("result shown while still busy");

	// reset empties the output and opens the input
	a_reset_state: assert property (@(posedge clk)
		!arst_n |-> !m_axis_tvalid && s_axis_tready)
		else $error("bad handshake state in reset");

endmodule

bind fin_actuator_second_order_model_unit famu_checker u_famu_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

### tb/sv/fin_actuator_second_order_model_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for fin_actuator_second_order_model_unit: streams roll/pitch/yaw ticks, predicts the
// four-fin actuator response with a behavioral model and checks every result transaction.
// Depends on famu_pkg and the unit's RTL.
module fin_actuator_second_order_model_unit_tb;
	import famu_pkg::*;

	localparam int          WATCHDOG_LIMIT  = 10000;
	localparam int          HOLD_OFF_CYCLES = 1500;
	localparam int          SETTLE_CYCLES   = 300;
	localparam int          RANDOM_PHASES   = 8;
	localparam int          PHASE_TICKS     = 58;
	localparam logic [95:0] PROD_CAP        = 96'h3FFF_FFFF_FFFF_FFFF;
	localparam logic [31:0] CMD_MAX         = 32'h7FFF_FFFF;
	localparam logic [31:0] CMD_MIN         = 32'h8000_0000;
	localparam logic [31:0] CMD_ODD         = 32'h5555_5555;
	localparam logic [31:0] CMD_EVEN        = 32'hAAAA_AAAA;

	typedef struct {
		logic signed [31:0] roll;
		logic signed [31:0] pitch;
		logic signed [31:0] yaw;
	} deflection_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	// roll_command [31:0], pitch_command [63:32], yaw_command [95:64]
	logic [TDATA_W-1:0]    s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	// roll_deflection [31:0], pitch_deflection [63:32], yaw_deflection [95:64]
	logic [TDATA_W-1:0]    m_axis_tdata;

	// traffic control shared by the sender, the sink and the tests
	bit idle_on;
	bit hold_off_req;
	int mismatch_count;

	deflection_t expected_deflections[$];

	// behavioral copy of the configuration and the per-fin state
	logic [30:0] mdl_pos_limit;
	logic [30:0] mdl_rate_limit;
	logic [23:0] mdl_wn;
	logic [15:0] mdl_zeta;
	logic [31:0] mdl_dt;
	longint      act_pos   [FINS];
	longint      act_slope [FINS];
	longint      act_vel   [FINS];
	longint      act_acc   [FINS];

	fin_actuator_second_order_model_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- prediction

	function automatic longint sat_signed(longint v, int w);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	// exact product, magnitude shifted toward zero, capped at 62 bits
	function automatic longint scaled_product(longint a, logic [31:0] b, int sh);
		logic [63:0] mag;
		logic [95:0] prod;
		longint      r;
		mag  = (a < 0) ? -a : a;
		prod = {32'd0, mag} * {64'd0, b};
		prod = prod >> sh;
		if (prod > PROD_CAP)
			r = longint'(PROD_CAP[63:0]);
		else
			r = prod[63:0];
		return (a < 0) ? -r : r;
	endfunction

	function automatic bit same_dir(longint a, longint b);
		return (a > 0 && b > 0) || (a < 0 && b < 0);
	endfunction

	function automatic longint quarter(longint v);
		return (v < 0) ? -((-v) / 4) : v / 4;
	endfunction

	function automatic void step_fin(int i, longint cmd);
		longint plim;
		longint rlim;
		longint pos;
		longint vel;
		longint err;
		longint t;
		longint c;
		longint acc;
		longint mag;
		bit     rate_clamped;
		plim         = longint'(mdl_pos_limit);
		rlim         = longint'(mdl_rate_limit);
		pos          = act_pos[i];
		vel          = act_vel[i];
		rate_clamped = 1'b0;
		// hold the position at its stop and drop an outward rate there
		mag = (pos < 0) ? -pos : pos;
		if (mag > plim) begin
			pos = (pos < 0) ? -plim : plim;
			if (same_dir(pos, vel))
				vel = 0;
		end
		mag = (vel < 0) ? -vel : vel;
		if (mag > rlim) begin
			rate_clamped = 1'b1;
			vel = (vel < 0) ? -rlim : rlim;
		end
		// trapezoidal position update with the clamped rate
		pos          = sat_signed(pos + scaled_product(vel + act_slope[i], mdl_dt, 33), 40);
		act_pos[i]   = pos;
		act_slope[i] = vel;
		// second-order acceleration
		err = sat_signed(cmd - pos, 41);
		t   = sat_signed(scaled_product(err, 32'(mdl_wn), 12), 48);
		t   = sat_signed(scaled_product(t, 32'(mdl_wn), 12), 48);
		c   = (longint'(mdl_zeta) * longint'(mdl_wn)) >>> 13;
		acc = sat_signed(t - scaled_product(vel, c[31:0], 12), 48);
		// trapezoidal rate update; drop the stored acceleration against the rate stop
		vel        = sat_signed(vel + scaled_product(acc + act_acc[i], mdl_dt, 33), 40);
		act_vel[i] = vel;
		act_acc[i] = (rate_clamped && same_dir(vel, acc)) ? 0 : acc;
	endfunction

	function automatic deflection_t predict_deflection(logic [31:0] r, logic [31:0] p,
		logic [31:0] y);
		longint      rc;
		longint      pc;
		longint      yc;
		deflection_t d;
		rc = longint'(signed'(r));
		pc = longint'(signed'(p));
		yc = longint'(signed'(y));
		step_fin(0, -rc + pc - yc);
		step_fin(1, -rc + pc + yc);
		step_fin(2, rc + pc - yc);
		step_fin(3, rc + pc + yc);
		d.roll  = 32'(sat_signed(quarter(-act_pos[0] - act_pos[1] + act_pos[2] + act_pos[3]),
			32));
		d.pitch = 32'(sat_signed(quarter(act_pos[0] + act_pos[1] + act_pos[2] + act_pos[3]),
			32));
		d.yaw   = 32'(sat_signed(quarter(-act_pos[0] + act_pos[1] - act_pos[2] + act_pos[3]),
			32));
		return d;
	endfunction

	function automatic void reset_model();
		mdl_pos_limit  = POS_LIMIT_RST;
		mdl_rate_limit = RATE_LIMIT_RST;
		mdl_wn         = NAT_FREQ_RST;
		mdl_zeta       = DAMPING_RST;
		mdl_dt         = TIME_STEP_RST;
		for (int i = 0; i < FINS; i++) begin
			act_pos[i]   = 0;
			act_slope[i] = 0;
			act_vel[i]   = 0;
			act_acc[i]   = 0;
		end
	endfunction

	// ---------------------------------------------------------------- stimulus helpers

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 4);
		if (roll < 97)
			return $urandom_range(5, 30);
		return $urandom_range(100, 400);
	endfunction

	// command within a few radians most of the time, full range otherwise
	function automatic logic [31:0] random_cmd();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 5)
			return 32'($urandom_range(0, 32'h0800_0000)) - 32'h0400_0000;
		if (roll < 7)
			return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
		return $urandom();
	endfunction

	task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	// write every register, then one index past the list that must be ignored
	task automatic set_config(logic [30:0] plim, logic [30:0] rlim, logic [23:0] wn,
		logic [15:0] zeta, logic [31:0] dt);
		write_reg(CFG_IDX_POS_LIMIT, 32'(plim));
		write_reg(CFG_IDX_RATE_LIMIT, 32'(rlim));
		write_reg(CFG_IDX_NAT_FREQ, 32'(wn));
		write_reg(CFG_IDX_DAMPING, 32'(zeta));
		write_reg(CFG_IDX_TIME_STEP, dt);
		write_reg(CFG_IDX_TIME_STEP + CFG_ADDR_W'($urandom_range(1, 3)), $urandom());
		cfg_we <= 1'b0;
		@(posedge clk);
		mdl_pos_limit  = plim;
		mdl_rate_limit = rlim;
		mdl_wn         = wn;
		mdl_zeta       = zeta;
		mdl_dt         = dt;
	endtask

	// offer one tick and record its prediction once the transaction completes
	task automatic send_tick(logic [31:0] r, logic [31:0] p, logic [31:0] y);
		int gap;
		gap = idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {y, p, r};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		expected_deflections.push_back(predict_deflection(r, p, y));
	endtask

	// stop offering and wait until every expected result has come back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (expected_deflections.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_default_config();
		idle_on = 1'b1;
		set_config(POS_LIMIT_RST, RATE_LIMIT_RST, NAT_FREQ_RST, DAMPING_RST, TIME_STEP_RST);
		send_tick(32'd0, 32'd0, 32'd0);
		send_tick(CMD_MAX, 32'd0, 32'd0);
		send_tick(CMD_MIN, 32'd0, 32'd0);
		send_tick(32'd0, CMD_MAX, 32'd0);
		send_tick(32'd0, CMD_MIN, 32'd0);
		send_tick(32'd0, 32'd0, CMD_MAX);
		send_tick(32'd0, 32'd0, CMD_MIN);
		send_tick(CMD_MAX, CMD_MAX, CMD_MAX);
		send_tick(CMD_MIN, CMD_MIN, CMD_MIN);
		send_tick(CMD_ODD, CMD_EVEN, CMD_ODD);
		send_tick(CMD_EVEN, CMD_ODD, CMD_EVEN);
		drain();
	endtask

	// a nonzero position collapses to zero at a zero stop
	task automatic test_zero_position_limit();
		set_config(31'd0, RATE_LIMIT_RST, NAT_FREQ_RST, DAMPING_RST, TIME_STEP_RST);
		repeat (3) send_tick(random_cmd(), random_cmd(), random_cmd());
		drain();
	endtask

	// any nonzero rate hits the stop
	task automatic test_zero_rate_limit();
		set_config(POS_LIMIT_RST, 31'd0, NAT_FREQ_RST, DAMPING_RST, TIME_STEP_RST);
		repeat (3) send_tick(random_cmd(), random_cmd(), random_cmd());
		drain();
	endtask

	// positions and rates freeze
	task automatic test_zero_time_step();
		set_config(POS_LIMIT_RST, RATE_LIMIT_RST, NAT_FREQ_RST, DAMPING_RST, 32'd0);
		repeat (3) send_tick(random_cmd(), random_cmd(), random_cmd());
		drain();
	endtask

	// every register at its top value, commands at the rails to force saturation
	task automatic test_extreme_config();
		set_config(31'h7FFF_FFFF, 31'h7FFF_FFFF, 24'hFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
		send_tick(CMD_MAX, CMD_MAX, CMD_MAX);
		send_tick(CMD_MIN, CMD_MIN, CMD_MIN);
		send_tick(CMD_MAX, CMD_MIN, CMD_MAX);
		send_tick(CMD_MIN, CMD_MAX, CMD_MIN);
		drain();
	endtask

	// held command steps with random content, some noise ticks in between
	task automatic test_random_ticks();
		logic [31:0] r;
		logic [31:0] p;
		logic [31:0] y;
		int          seg_left;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			idle_on = (phase % 3) != 2;
			if (phase == 0)
				set_config(31'd0, 31'd0, 24'd0, 16'd0, 32'd1);
			else if (phase == 1)
				set_config(31'h7FFF_FFFF, 31'h7FFF_FFFF, 24'hFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
			else if ($urandom_range(0, 3) == 0)
				set_config(31'($urandom()), 31'($urandom()), 24'($urandom()),
					16'($urandom()), $urandom());
			else
				set_config(31'($urandom_range(0, 32'h0200_0000)),
					31'($urandom_range(0, 32'h2000_0000)),
					24'($urandom_range(0, 24'h0F_FFFF)),
					16'($urandom_range(0, 16'hFFFF)),
					32'($urandom_range(1, 32'h0100_0000)));
			seg_left = 0;
			for (int n = 0; n < PHASE_TICKS; n++) begin
				if (seg_left == 0) begin
					r        = random_cmd();
					p        = random_cmd();
					y        = random_cmd();
					seg_left = $urandom_range(1, 20);
				end
				seg_left--;
				if ($urandom_range(0, 9) == 0)
					send_tick($urandom(), $urandom(), $urandom());
				else
					send_tick(r, p, y);
			end
			drain();
		end
	endtask

	// sink holds off while ticks keep coming, so the unit fills and stalls its input
	task automatic test_back_pressure();
		idle_on = 1'b0;
		set_config(POS_LIMIT_RST, RATE_LIMIT_RST, NAT_FREQ_RST, DAMPING_RST, TIME_STEP_RST);
		hold_off_req = 1'b1;
		repeat (12) send_tick(random_cmd(), random_cmd(), random_cmd());
		drain();
		idle_on = 1'b1;
	endtask

	// ---------------------------------------------------------------- result side

	// accept results with random stalls, or hold off for a long stretch on request
	initial begin : result_sink
		int stall_left;
		stall_left    = 0;
		m_axis_tready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else if (idle_on && stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
				@(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				if (idle_on && $urandom_range(0, 9) == 0)
					stall_left = pick_gap();
				@(posedge clk);
			end
		end
	end

	// compare each result transaction with the oldest prediction
	always @(posedge clk) begin : check_results
		deflection_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_deflections.size() == 0) begin
				$display("%0t: result with nothing expected, got %h", $time, m_axis_tdata);
				mismatch_count++;
			end else begin
				want = expected_deflections.pop_front();
				if (m_axis_tdata[31:0] !== want.roll) begin
					$display("%0t: roll_deflection expected %h got %h", $time, want.roll,
						m_axis_tdata[31:0]);
					mismatch_count++;
				end
				if (m_axis_tdata[63:32] !== want.pitch) begin
					$display("%0t: pitch_deflection expected %h got %h", $time, want.pitch,
						m_axis_tdata[63:32]);
					mismatch_count++;
				end
				if (m_axis_tdata[95:64] !== want.yaw) begin
					$display("%0t: yaw_deflection expected %h got %h", $time, want.yaw,
						m_axis_tdata[95:64]);
					mismatch_count++;
				end
			end
		end
	end

	// end the run if no transaction moves for too long
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_addr       = '0;
		cfg_data       = '0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		idle_on        = 1'b1;
		hold_off_req   = 1'b0;
		mismatch_count = 0;
		reset_model();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_config();
		test_zero_position_limit();
		test_zero_rate_limit();
		test_zero_time_step();
		test_extreme_config();
		test_random_ticks();
		test_back_pressure();

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_deflections.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
